/* hw/rtl/ptts_pkg.sv */
package ptts_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TICK_LEN_DEF  = 1;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_KILL = 2'd1;
    localparam logic [1:0] CMD_TIME = 2'd2;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        step;
        logic        clr;
        logic        op_add;
        logic        op_time;
        logic        claimed;
        logic [31:0] now;
        logic [31:0] first_q;
        logic [31:0] period_q;
        logic [15:0] runs;
        logic        endless;
    } t_bcast;

endpackage

/* hw/rtl/ptts_cdiv.sv */
module ptts_cdiv #(
    parameter int TICK_LEN = ptts_pkg::TICK_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    output logic [31:0] o_q,
    output logic        o_done
);
    import ptts_pkg::*;

    localparam int L  = $clog2(TICK_LEN);
    localparam int K  = 32 + L;
    localparam int PW = K + 32;
    localparam int DW = $clog2(TICK_LEN + 1);
    localparam logic [63:0] RecipFull = (64'd1 << K) / TICK_LEN;
    localparam logic [32:0] Recip     = RecipFull[32:0];
    localparam logic [DW-1:0] Div     = DW'(TICK_LEN);

    logic [2:0]       r_vld;
    logic [PW-1:0]    r_prod;
    logic [31:0]      r_x1;
    logic [31:0]      r_x2;
    logic [31:0]      r_x3;
    logic [31:0]      r_qe;
    logic [31:0]      r_qe3;
    logic [31+DW:0]   r_qd;
    logic [31:0]      n_rem;
    logic [31:0]      r_q;
    logic             r_done;

    // floor reciprocal: estimate is exact or one low
    assign n_rem = r_x3 - r_qd[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_start};
            r_done <= r_vld[2];
        end
        r_prod <= PW'(i_x) * PW'(Recip);
        r_x1   <= i_x;
        r_qe   <= r_prod[PW-1:K];
        r_x2   <= r_x1;
        r_qd   <= (32 + DW)'(r_qe) * (32 + DW)'(Div);
        r_qe3  <= r_qe;
        r_x3   <= r_x2;
        r_q    <= (n_rem >= 32'(Div)) ? r_qe3 + 32'd1 : r_qe3;
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

/* hw/rtl/ptts_cell.sv */
module ptts_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptts_pkg::t_bcast i_bc,
    input  logic            i_tok,
    input  logic            i_kill,
    output logic            o_tok,
    output logic            o_hit
);
    import ptts_pkg::*;

    logic        r_busy;
    logic [31:0] r_due;
    logic [31:0] r_period;
    logic [15:0] r_runs;
    logic        r_endless;
    logic        r_tok;
    logic        act;
    logic        claim;
    logic        fire;

    assign act   = i_tok & i_bc.step;
    assign claim = act & i_bc.op_add & !r_busy & !i_bc.claimed;
    assign fire  = act & i_bc.op_time & r_busy & (r_due == i_bc.now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            if (i_bc.clr) begin
                r_tok <= 1'b0;
            end else if (i_bc.step) begin
                r_tok <= i_tok;
            end
            if (i_kill) begin
                r_busy <= 1'b0;
            end else if (claim) begin
                r_busy <= 1'b1;
            end else if (fire && !r_endless && r_runs <= 16'd1) begin
                r_busy <= 1'b0;
            end
        end
        if (claim) begin
            r_due     <= i_bc.first_q;
            r_period  <= i_bc.period_q;
            r_runs    <= i_bc.runs;
            r_endless <= i_bc.endless;
        end else if (fire) begin
            r_due <= i_bc.now + r_period;
            if (!r_endless) begin
                r_runs <= (r_runs <= 16'd1) ? 16'd0 : r_runs - 16'd1;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_hit = claim | fire;

endmodule

/* hw/rtl/periodic_task_tick_scheduler.sv */
// Channel | Signals                                   | Direction
// in      | i_in_valid/o_in_ready, cmd..now           | word in
// out     | o_out_valid/i_out_ready, kind, slot, last | word out
//
// Add: accept, divide of the first due time and the period, token walk along the cell chain, flush.
// Time update: accept, token walk along the cell chain, flush.
// Kill, repeated tick and reserved words never leave the idle state and give no output word.
// The token walks one cell per cycle; it halts while the output register is held.
// Synchronous active-low reset frees all slots and clears the previous tick.
// A new word is taken only when the previous one is complete.
module periodic_task_tick_scheduler #(
    parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF,
    parameter int TICK_LEN  = ptts_pkg::TICK_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_first_due,
    input  logic [31:0] i_repeat_every,
    input  logic [15:0] i_run_count,
    input  logic        i_forever_req,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_task_slot,
    output logic        o_last
);
    import ptts_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_FLUSH} t_state;

    t_state         r_state;
    logic           r_op_add;
    logic [31:0]    r_prev_now;
    logic [31:0]    r_now;
    logic [31:0]    r_first;
    logic [31:0]    r_rep;
    logic [15:0]    r_runs;
    logic           r_endless;
    logic [IW-1:0]  r_idx;
    logic           r_pvalid;
    logic [IW-1:0]  r_pslot;
    logic           r_ovalid;
    logic [1:0]     r_okind;
    logic [3:0]     r_oslot;
    logic           r_olast;

    logic           accept;
    logic           can_push;
    logic           div_start;
    logic           div_done;
    logic           div_done_a;
    logic           div_done_b;
    logic [31:0]    first_q;
    logic [31:0]    rep_q;
    logic           any_hit;
    logic           push;
    logic           push_last;
    t_bcast         bc;
    logic [NUM_SLOTS-1:0] tok_vec;
    logic [NUM_SLOTS-1:0] hit_vec;
    logic [NUM_SLOTS-1:0] kill_vec;
    logic [NUM_SLOTS:0]   tok_chain;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign can_push   = !r_ovalid | i_out_ready;
    assign div_start  = accept & (i_cmd == CMD_ADD);
    assign any_hit    = |hit_vec;

    ptts_cdiv #(.TICK_LEN(TICK_LEN)) u_div_first (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_x(r_first), .o_q(first_q), .o_done(div_done_a)
    );
    ptts_cdiv #(.TICK_LEN(TICK_LEN)) u_div_rep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_x(r_rep), .o_q(rep_q), .o_done(div_done_b)
    );
    assign div_done = div_done_a & div_done_b;

    always_comb begin
        bc          = '0;
        bc.step     = (r_state == S_SCAN) & can_push;
        bc.clr      = (r_state == S_FLUSH) & can_push;
        bc.op_add   = r_op_add;
        bc.op_time  = !r_op_add;
        bc.claimed  = r_pvalid;
        bc.now      = r_now;
        bc.first_q  = first_q;
        bc.period_q = rep_q;
        bc.runs     = r_runs;
        bc.endless  = r_endless;
    end

    assign tok_chain[0] = (r_state == S_SCAN) & (r_idx == '0) & !tok_vec[NUM_SLOTS-1]
                          & !(|tok_vec);

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        assign kill_vec[k] = accept & (i_cmd == CMD_KILL) & (32'(i_slot) == 32'(k));
        ptts_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bc   (bc),
            .i_tok  (tok_chain[k]),
            .i_kill (kill_vec[k]),
            .o_tok  (tok_chain[k+1]),
            .o_hit  (hit_vec[k])
        );
        assign tok_vec[k] = tok_chain[k+1];
    end

    // fired results lag one hit so the last one can be marked
    always_comb begin
        push      = 1'b0;
        push_last = 1'b0;
        if (r_state == S_SCAN && bc.step && any_hit && !r_op_add && r_pvalid) begin
            push = 1'b1;
        end else if (r_state == S_FLUSH && can_push && (r_op_add || r_pvalid)) begin
            push      = 1'b1;
            push_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_now <= '0;
            r_pvalid   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_op_add   <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_pvalid <= 1'b0;
                    if (accept && i_cmd == CMD_ADD) begin
                        r_op_add <= 1'b1;
                        r_state  <= S_DIV;
                    end else if (accept && i_cmd == CMD_TIME && i_now != r_prev_now) begin
                        r_op_add   <= 1'b0;
                        r_prev_now <= i_now;
                        r_state    <= S_SCAN;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (bc.step) begin
                        r_idx <= r_idx + IW'(1);
                        if (any_hit) begin
                            r_pvalid <= 1'b1;
                            r_pslot  <= r_idx;
                        end
                    end
                    if (tok_vec[NUM_SLOTS-1]) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (can_push) begin
                        r_pvalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (accept) begin
            r_now     <= i_now;
            r_first   <= i_first_due;
            r_rep     <= i_repeat_every;
            r_runs    <= i_run_count;
            r_endless <= i_forever_req;
        end
        if (push) begin
            r_olast <= push_last;
            if (r_op_add) begin
                r_okind <= r_pvalid ? KIND_ACCEPT : KIND_REJECT;
                r_oslot <= r_pvalid ? 4'(r_pslot) : '0;
            end else begin
                r_okind <= KIND_FIRED;
                r_oslot <= 4'(r_pslot);
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_task_slot = r_oslot;
    assign o_last      = r_olast;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one token in the cell chain");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell hit in a step");

    a_mid_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !push_last |-> r_state == S_SCAN && !r_op_add)
        else $error("non-final result outside a time scan");

    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH && can_push |=> r_state == S_IDLE && !r_pvalid)
        else $error("flush did not return to idle");

endmodule
